@@ sv/sct_pkg.sv @@
// shared types and constants of the sorted chunk table
package sct_pkg;

   localparam int DEFAULT_CAPACITY = 32;
   localparam int DEFAULT_KEY_BITS = 32;

   // operation codes
   localparam logic [2:0] OP_APPEND      = 3'd0;
   localparam logic [2:0] OP_INSERT      = 3'd1;
   localparam logic [2:0] OP_REMOVE_ZERO = 3'd2;
   localparam logic [2:0] OP_REMOVE_AT   = 3'd3;
   localparam logic [2:0] OP_CLEAR       = 3'd4;
   localparam logic [2:0] OP_READ        = 3'd5;

   // status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   typedef struct packed {
      logic [2:0]  operation;
      logic [31:0] entry_key;
      logic [31:0] entry_size;
      logic [31:0] entry_payload;
      logic [4:0]  target_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  entry_count;
      logic [31:0] read_key;
      logic [31:0] read_size;
      logic [31:0] read_payload;
   } rsp_type;

   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_APPEND,
      CMD_INSERT,
      CMD_REMOVE_AT,
      CMD_SQUEEZE
   } cell_cmd_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      cell_cmd_type cmd;
      logic [31:0]  new_size;
      logic [31:0]  new_payload;
   } cell_ctrl_type;

endpackage

@@ sv/sct_cell.sv @@
// one table slot: holds an entry and shifts it to or from its neighbors
module sct_cell #(
   parameter int INDEX    = 0,
   parameter int KEY_BITS = sct_pkg::DEFAULT_KEY_BITS,
   parameter int CNT_W    = 6
) (
   input  logic                  clock,
   input  sct_pkg::cell_ctrl_type ctrl,
   input  logic [KEY_BITS-1:0]   new_key,
   input  logic [CNT_W-1:0]      count,
   input  logic [CNT_W-1:0]      target,
   input  logic [KEY_BITS-1:0]   lower_key,
   input  logic [31:0]           lower_size,
   input  logic [31:0]           lower_payload,
   input  logic [KEY_BITS-1:0]   upper_key,
   input  logic [31:0]           upper_size,
   input  logic [31:0]           upper_payload,
   input  logic                  gt_in,
   input  logic                  gt_lower,
   input  logic                  zero_in,
   output logic                  gt_out,
   output logic                  zero_out,
   output logic [KEY_BITS-1:0]   key_q,
   output logic [31:0]           size_q,
   output logic [31:0]           payload_q
);

   localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(INDEX);

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [31:0]         size_ff, size_in;
   logic [31:0]         payload_ff, payload_in;
   logic                occupied;

   assign occupied = MY_INDEX < count;
   // every occupied slot from here up has a key above the new one
   assign gt_out   = gt_in & (!occupied | (new_key < key_ff));
   // some occupied slot from here down has zero size
   assign zero_out = zero_in | (occupied & (size_ff == 32'd0));

   always_comb begin
      key_in     = key_ff;
      size_in    = size_ff;
      payload_in = payload_ff;
      case (ctrl.cmd)
         sct_pkg::CMD_APPEND: begin
            if (MY_INDEX == count) begin
               key_in     = new_key;
               size_in    = ctrl.new_size;
               payload_in = ctrl.new_payload;
            end
         end
         sct_pkg::CMD_INSERT: begin
            if (gt_out) begin
               if (gt_lower) begin
                  key_in     = lower_key;
                  size_in    = lower_size;
                  payload_in = lower_payload;
               end else begin
                  key_in     = new_key;
                  size_in    = ctrl.new_size;
                  payload_in = ctrl.new_payload;
               end
            end
         end
         sct_pkg::CMD_REMOVE_AT: begin
            if (MY_INDEX >= target) begin
               key_in     = upper_key;
               size_in    = upper_size;
               payload_in = upper_payload;
            end
         end
         sct_pkg::CMD_SQUEEZE: begin
            if (zero_out) begin
               key_in     = upper_key;
               size_in    = upper_size;
               payload_in = upper_payload;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      size_ff    <= size_in;
      payload_ff <= payload_in;
   end

   assign key_q     = key_ff;
   assign size_q    = size_ff;
   assign payload_q = payload_ff;

endmodule

@@ sv/sorted_chunk_table.sv @@
// top level of the sorted chunk table: controller, cell chain and result register
//
// usage: one request transaction carries an operation (append, sorted insert,
// remove zero-size entries, remove by index, clear, read) plus a new entry and
// an index; each request yields exactly one response transaction with status,
// entry count after the operation and, for a read, the entry's fields.
// the table is a row of CAPACITY cells; one entry per cell. insert and removal
// shift all affected cells by one slot in the same clock edge.
// the response is registered and appears the cycle after the request is taken
// for append, insert, remove by index, clear and read. removing zero-size
// entries answers once compaction is done, and meanwhile the chain drops the
// lowest zero-size entry once per cycle.
// req_stall is high while that compaction runs and while a response waits
// under rsp_stall; a stalled response holds its value.
// reset clears the state, the entry count and the response valid; cell
// contents are left as they are and are never read before being written.
// append or insert into a full table answers status full and changes nothing;
// remove or read beyond the count answers status range.
module sorted_chunk_table #(
   parameter int CAPACITY = sct_pkg::DEFAULT_CAPACITY,
   parameter int KEY_BITS = sct_pkg::DEFAULT_KEY_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sct_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sct_pkg::rsp_type rsp_data
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (CNT_W > 5) ? CNT_W : 5;
   localparam int READ_N = (CAPACITY < 32) ? CAPACITY : 32;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

   typedef enum logic {ST_IDLE, ST_SQUEEZE} state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   sct_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // cell row wiring
   logic [KEY_BITS-1:0] cell_key     [CAPACITY];
   logic [31:0]         cell_size    [CAPACITY];
   logic [31:0]         cell_payload [CAPACITY];
   logic [CAPACITY:0]   gt_chain;    // gt_chain[i] leaves cell i downward
   logic [CAPACITY:0]   zero_chain;  // zero_chain[i+1] leaves cell i upward

   sct_pkg::cell_ctrl_type ctrl;
   logic [KEY_BITS-1:0]    new_key;
   logic [CNT_W-1:0]       target;
   logic                   accept;
   logic                   out_free;
   logic                   full;
   logic                   in_range;
   logic                   any_zero;
   logic [31:0]            rd_key, rd_size, rd_payload;

   assign out_free  = !rsp_valid_ff | !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) | !out_free;
   assign accept    = req_valid & !req_stall;

   assign full     = count_ff == FULL_COUNT;
   assign in_range = CMP_W'(req_data.target_index) < CMP_W'(count_ff);
   assign any_zero = zero_chain[CAPACITY];
   // only used while in range, so it fits the count width
   assign target   = CNT_W'(req_data.target_index);
   assign new_key  = KEY_BITS'(req_data.entry_key);

   assign gt_chain[CAPACITY] = 1'b1;
   assign zero_chain[0]      = 1'b0;

   for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [KEY_BITS-1:0] lo_key, up_key;
      logic [31:0]         lo_size, lo_payload, up_size, up_payload;
      logic                lo_gt;

      if (gi == 0) begin : g_bottom
         assign lo_key     = '0;
         assign lo_size    = '0;
         assign lo_payload = '0;
         assign lo_gt      = 1'b0;
      end else begin : g_mid_lo
         assign lo_key     = cell_key[gi-1];
         assign lo_size    = cell_size[gi-1];
         assign lo_payload = cell_payload[gi-1];
         assign lo_gt      = gt_chain[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_top
         assign up_key     = '0;
         assign up_size    = '0;
         assign up_payload = '0;
      end else begin : g_mid_up
         assign up_key     = cell_key[gi+1];
         assign up_size    = cell_size[gi+1];
         assign up_payload = cell_payload[gi+1];
      end

      sct_cell #(
         .INDEX   (gi),
         .KEY_BITS(KEY_BITS),
         .CNT_W   (CNT_W)
      ) u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .new_key      (new_key),
         .count        (count_ff),
         .target       (target),
         .lower_key    (lo_key),
         .lower_size   (lo_size),
         .lower_payload(lo_payload),
         .upper_key    (up_key),
         .upper_size   (up_size),
         .upper_payload(up_payload),
         .gt_in        (gt_chain[gi+1]),
         .gt_lower     (lo_gt),
         .zero_in      (zero_chain[gi]),
         .gt_out       (gt_chain[gi]),
         .zero_out     (zero_chain[gi+1]),
         .key_q        (cell_key[gi]),
         .size_q       (cell_size[gi]),
         .payload_q    (cell_payload[gi])
      );
   end

   // read select over the slots a 5-bit index can reach
   always_comb begin
      rd_key     = '0;
      rd_size    = '0;
      rd_payload = '0;
      for (int i = 0; i < READ_N; i++) begin
         if (req_data.target_index == 5'(i)) begin
            rd_key     = 32'(cell_key[i]);
            rd_size    = cell_size[i];
            rd_payload = cell_payload[i];
         end
      end
   end

   // controller: cell command, count update and response
   always_comb begin
      ctrl.cmd         = sct_pkg::CMD_HOLD;
      ctrl.new_size    = req_data.entry_size;
      ctrl.new_payload = req_data.entry_payload;
      state_in         = state_ff;
      count_in         = count_ff;
      rsp_valid_in     = rsp_valid_ff & rsp_stall;
      rsp_data_in      = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               case (req_data.operation)
                  sct_pkg::OP_APPEND, sct_pkg::OP_INSERT: begin
                     if (full) begin
                        rsp_data_in.status = sct_pkg::STATUS_FULL;
                     end else begin
                        ctrl.cmd = (req_data.operation == sct_pkg::OP_APPEND) ?
                                   sct_pkg::CMD_APPEND : sct_pkg::CMD_INSERT;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  sct_pkg::OP_REMOVE_ZERO: begin
                     // response comes when compaction is done
                     rsp_valid_in = 1'b0;
                     state_in     = ST_SQUEEZE;
                  end
                  sct_pkg::OP_REMOVE_AT: begin
                     if (in_range) begin
                        ctrl.cmd = sct_pkg::CMD_REMOVE_AT;
                        count_in = count_ff - CNT_W'(1);
                     end else begin
                        rsp_data_in.status = sct_pkg::STATUS_RANGE;
                     end
                  end
                  sct_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  sct_pkg::OP_READ: begin
                     if (in_range) begin
                        rsp_data_in.read_key     = rd_key;
                        rsp_data_in.read_size    = rd_size;
                        rsp_data_in.read_payload = rd_payload;
                     end else begin
                        rsp_data_in.status = sct_pkg::STATUS_RANGE;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_data_in.entry_count = 6'(count_in);
            end
         end
         ST_SQUEEZE: begin
            if (any_zero) begin
               // drop the lowest zero-size entry, upper ones slide down
               ctrl.cmd = sct_pkg::CMD_SQUEEZE;
               count_in = count_ff - CNT_W'(1);
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in.status      = sct_pkg::STATUS_OK;
               rsp_data_in.entry_count = 6'(count_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // count never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count above capacity");

   // each compaction step removes exactly one entry
   a_squeeze_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQUEEZE && any_zero) |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("compaction step did not drop one entry");

   // an append or insert into a full table leaves the count alone and answers full
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && full && (req_data.operation == sct_pkg::OP_APPEND ||
                          req_data.operation == sct_pkg::OP_INSERT))
      |=> (count_ff == $past(count_ff) && rsp_data_ff.status == sct_pkg::STATUS_FULL))
      else $error("full table changed by insert");

   // no request is taken while compaction runs
   a_squeeze_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQUEEZE) |-> !accept)
      else $error("request taken during compaction");

endmodule
